// ===== src/tcspq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcspq_pkg
// Shared types and constants of the two-class severity priority queue.
// ----------------------------------------------------------------------------
package tcspq_pkg;

  localparam int unsigned DEPTH_PER_LEVEL = 16;
  localparam int unsigned NUM_LEVELS      = 6;
  localparam int unsigned MAX_SEVERITY    = 5;
  localparam int unsigned TICKET_W        = 16;
  localparam int unsigned LVL_W           = 3;
  localparam int unsigned PTR_W           = $clog2(DEPTH_PER_LEVEL);
  localparam int unsigned CNT_W           = $clog2(DEPTH_PER_LEVEL + 1);
  localparam int unsigned SUM_W           = CNT_W + 1;
  localparam int unsigned ADDR_W          = $clog2(NUM_LEVELS * DEPTH_PER_LEVEL);
  localparam logic [TICKET_W-1:0] TICKET_START = 16'd1000;

  typedef enum logic [1:0] {
    REQ_ADMIT_NORMAL = 2'd0,
    REQ_ADMIT_URGENT = 2'd1,
    REQ_SERVE        = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_ADMITTED = 3'd0,
    ST_SERVED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD_SEV  = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] severity;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [TICKET_W-1:0] ticket_id;
    logic [LVL_W-1:0]    level;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_rd;
  } cmd_t;

  typedef struct packed {
    logic serve_hit;
  } sts_t;

endpackage

// ===== src/two_class_severity_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_severity_priority_queue
// Strict priority queue of tickets: five urgent levels over one normal level,
// first in first out within each level.
// ----------------------------------------------------------------------------
// One request is handled at a time. An accepted request passes through an
// execute state, and a serve that finds an entry also through a read state,
// since the served ticket comes out of the registered read port of the
// ticket store. The response is then held until taken; the next request is
// accepted in the cycle after that, so a new request can enter only once the
// previous response has been taken. The ticket store needs no clearing after
// reset.
module two_class_severity_priority_queue import tcspq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  tcspq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tcspq_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (in_data_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (out_data_o)
  );

endmodule

// ===== src/tcspq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcspq_ctrl
// Sequencer: takes one request, runs it through the datapath, holds the
// response until the output transaction completes.
// ----------------------------------------------------------------------------
module tcspq_ctrl import tcspq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.serve_hit ? S_READ : S_RESP;
      end
      S_READ: begin
        cmd_o.load_rd = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted transaction did not start execution");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a response is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("response dropped before it was taken");

endmodule

// ===== src/tcspq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcspq_dp
// Datapath: per-level ring buffers in one ticket store, head and count
// registers, ticket counter, priority encoder and response register.
// ----------------------------------------------------------------------------
module tcspq_dp import tcspq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output rsp_t rsp_o
);

  req_t                req_q;
  rsp_t                rsp_q, rsp_d;
  logic [TICKET_W-1:0] ticket_q, ticket_d;
  logic [PTR_W-1:0]    head_q [NUM_LEVELS];
  logic [PTR_W-1:0]    head_d [NUM_LEVELS];
  logic [CNT_W-1:0]    count_q [NUM_LEVELS];
  logic [CNT_W-1:0]    count_d [NUM_LEVELS];

  logic [TICKET_W-1:0] mem [NUM_LEVELS * DEPTH_PER_LEVEL];
  logic [TICKET_W-1:0] rd_data_q;

  logic                enc_hit;
  logic [LVL_W-1:0]    enc_lv;
  logic                sev_ok;
  logic [LVL_W-1:0]    admit_lv;
  logic [LVL_W-1:0]    sel_lv;
  logic [PTR_W-1:0]    sel_head;
  logic [CNT_W-1:0]    sel_cnt;
  logic [SUM_W-1:0]    tail_sum;
  logic [PTR_W-1:0]    tail_ptr;
  logic [PTR_W-1:0]    head_inc;
  logic [ADDR_W-1:0]   lv_base;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic                we;
  logic                is_full;

  // highest nonempty level wins
  always_comb begin
    enc_hit = 1'b0;
    enc_lv  = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (count_q[i] != '0) begin
        enc_hit = 1'b1;
        enc_lv  = LVL_W'(i);
      end
    end
  end

  assign sev_ok   = (req_q.severity >= 3'd1) && (req_q.severity <= 3'(MAX_SEVERITY));
  assign admit_lv = (req_q.req_type == REQ_ADMIT_URGENT && sev_ok) ? req_q.severity : '0;
  assign sel_lv   = (req_q.req_type == REQ_SERVE) ? enc_lv : admit_lv;
  assign sel_head = head_q[sel_lv];
  assign sel_cnt  = count_q[sel_lv];
  assign is_full  = (sel_cnt == CNT_W'(DEPTH_PER_LEVEL));

  assign tail_sum = SUM_W'(sel_head) + SUM_W'(sel_cnt);
  assign tail_ptr = (tail_sum >= SUM_W'(DEPTH_PER_LEVEL))
                  ? PTR_W'(tail_sum - SUM_W'(DEPTH_PER_LEVEL))
                  : PTR_W'(tail_sum);
  assign head_inc = (sel_head == PTR_W'(DEPTH_PER_LEVEL - 1)) ? '0 : sel_head + 1'b1;

  assign lv_base  = ADDR_W'(sel_lv) * ADDR_W'(DEPTH_PER_LEVEL);
  assign waddr    = lv_base + ADDR_W'(tail_ptr);
  assign raddr    = lv_base + ADDR_W'(sel_head);

  always_comb begin
    rsp_d           = rsp_q;
    ticket_d        = ticket_q;
    head_d          = head_q;
    count_d         = count_q;
    we              = 1'b0;
    sts_o.serve_hit = 1'b0;
    if (cmd_i.exec) begin
      unique case (req_q.req_type)
        REQ_ADMIT_NORMAL, REQ_ADMIT_URGENT: begin
          if (req_q.req_type == REQ_ADMIT_URGENT && !sev_ok) begin
            rsp_d = '{status: ST_BAD_SEV, ticket_id: '0, level: '0};
          end else if (is_full) begin
            rsp_d = '{status: ST_FULL, ticket_id: '0, level: sel_lv};
          end else begin
            we              = 1'b1;
            count_d[sel_lv] = sel_cnt + 1'b1;
            ticket_d        = ticket_q + 1'b1;
            rsp_d = '{status: ST_ADMITTED, ticket_id: ticket_q, level: sel_lv};
          end
        end
        REQ_SERVE: begin
          if (enc_hit) begin
            sts_o.serve_hit = 1'b1;
            head_d[sel_lv]  = head_inc;
            count_d[sel_lv] = sel_cnt - 1'b1;
            rsp_d = '{status: ST_SERVED, ticket_id: '0, level: sel_lv};
          end else begin
            rsp_d = '{status: ST_EMPTY, ticket_id: '0, level: '0};
          end
        end
        default: begin
          rsp_d = '{status: ST_EMPTY, ticket_id: '0, level: '0};
        end
      endcase
    end else if (cmd_i.load_rd) begin
      rsp_d.ticket_id = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= ticket_q;
    end
    rd_data_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticket_q <= TICKET_START;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      ticket_q <= ticket_d;
      head_q   <= head_d;
      count_q  <= count_d;
    end
  end

  assign rsp_o = rsp_q;

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q[g] <= CNT_W'(DEPTH_PER_LEVEL))
      else $error("level occupancy above capacity");
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> (ticket_q == $past(ticket_q) + 1'b1))
    else $error("ticket counter not advanced on admission");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !is_full)
    else $error("write into a full level");

endmodule

// ===== test/tb_two_class_severity_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_class_severity_priority_queue
// Self-checking bench for the severity priority queue of tickets.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and sent in bursts with random
// gaps while the response side stalls on its own pattern. Each accepted
// request runs through a local triage model that tracks tickets, per-level
// occupancy and service order, and every response is compared field by
// field with the oldest prediction. Stimulus covers directed corner cases,
// fill and drain phases that push levels to full and empty, and a run of
// back-to-back serves that empties every level.
// ----------------------------------------------------------------------------
module tb_two_class_severity_priority_queue;
  import tcspq_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  two_class_severity_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // triage model state
  logic [TICKET_W-1:0] triage_ticket = TICKET_START;
  logic [TICKET_W-1:0] triage_slots [NUM_LEVELS][DEPTH_PER_LEVEL];
  int triage_head [NUM_LEVELS] = '{default: 0};
  int triage_fill [NUM_LEVELS] = '{default: 0};

  req_t pending_reqs [$];
  rsp_t triage_due [$];

  bit steady = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  int run_left = 0;
  int mismatches = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_bad_sev = 0;

  function automatic rsp_t triage_admit(int lv);
    rsp_t rs;
    rs = '0;
    rs.level = LVL_W'(lv);
    if (triage_fill[lv] >= int'(DEPTH_PER_LEVEL)) begin
      rs.status = ST_FULL;
    end else begin
      triage_slots[lv][(triage_head[lv] + triage_fill[lv]) % int'(DEPTH_PER_LEVEL)] =
        triage_ticket;
      triage_fill[lv]++;
      rs.status    = ST_ADMITTED;
      rs.ticket_id = triage_ticket;
      triage_ticket++;
    end
    return rs;
  endfunction

  function automatic rsp_t triage_outcome(req_t rq);
    rsp_t rs;
    rs = '0;
    rs.status = ST_EMPTY;
    case (rq.req_type)
      REQ_ADMIT_NORMAL: begin
        rs = triage_admit(0);
      end
      REQ_ADMIT_URGENT: begin
        if (rq.severity >= 3'd1 && rq.severity <= 3'(MAX_SEVERITY)) begin
          rs = triage_admit(int'(rq.severity));
        end else begin
          rs.status = ST_BAD_SEV;
        end
      end
      REQ_SERVE: begin
        for (int lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
          if (rs.status == ST_EMPTY && triage_fill[lv] != 0) begin
            rs.status    = ST_SERVED;
            rs.ticket_id = triage_slots[lv][triage_head[lv]];
            rs.level     = LVL_W'(lv);
            triage_head[lv] = (triage_head[lv] + 1) % int'(DEPTH_PER_LEVEL);
            triage_fill[lv]--;
          end
        end
      end
      default: begin
      end
    endcase
    return rs;
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic go;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        triage_due.push_back(triage_outcome(pending_reqs.pop_front()));
        n_sent++;
      end
      if (in_valid_i && !in_ready_o) begin
        go = 1'b1;
      end else if (gap_left > 0 && !steady) begin
        gap_left--;
        go = 1'b0;
      end else if (pending_reqs.size() > 0) begin
        go = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        go = 1'b0;
      end
      in_valid_i <= go;
      if (go) begin
        in_data_i <= pending_reqs[0];
      end
    end
  end

  task automatic note_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // monitor and response stalls
  always @(posedge clk_i) begin
    rsp_t want;
    logic rdy;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (triage_due.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %h", $time, out_data_o);
          mismatches++;
        end else begin
          want = triage_due.pop_front();
          note_field("status", want.status, out_data_o.status);
          note_field("ticket_id", want.ticket_id, out_data_o.ticket_id);
          note_field("level", want.level, out_data_o.level);
          n_checked++;
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_BAD_SEV) n_bad_sev++;
        end
      end
      if (steady) begin
        rdy = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left  = $urandom_range(0, 25);
          hold_left = $urandom_range(1, 7);
        end
      end
      out_ready_i <= rdy;
    end
  end

  task automatic add_request(logic [1:0] kind, logic [2:0] sev);
    req_t rq;
    rq.req_type = kind;
    rq.severity = sev;
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || in_valid_i || triage_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // alternating fill and drain phases, each fill aimed mostly at one level
  task automatic add_random(int want);
    int counted;
    int phase_left;
    bit filling;
    int hot;
    int target;
    int r;
    logic [1:0] kind;
    logic [2:0] sev;
    counted    = 0;
    phase_left = 0;
    filling    = 1'b0;
    hot        = 0;
    while (counted < want) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 45);
        filling    = !filling;
        hot        = $urandom_range(0, NUM_LEVELS - 1);
      end
      r   = $urandom_range(0, 99);
      sev = 3'($urandom_range(0, 7));
      if (r < 4) begin
        kind = REQ_UNUSED;
      end else if (r < 9) begin
        kind = REQ_ADMIT_URGENT;
        sev  = ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(6, 7));
      end else if ((filling && r < 80) || (!filling && r < 30)) begin
        target = ($urandom_range(0, 9) < 7) ? hot : $urandom_range(0, NUM_LEVELS - 1);
        if (target == 0) begin
          kind = REQ_ADMIT_NORMAL;
        end else begin
          kind = REQ_ADMIT_URGENT;
          sev  = 3'(target);
        end
      end else begin
        kind = REQ_SERVE;
      end
      add_request(kind, sev);
      if (kind != REQ_UNUSED) counted++;
      phase_left--;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_request(REQ_SERVE, 3'd0);
    add_request(REQ_UNUSED, 3'd7);
    add_request(REQ_ADMIT_URGENT, 3'd0);
    add_request(REQ_ADMIT_URGENT, 3'd6);
    add_request(REQ_ADMIT_URGENT, 3'd7);
    add_request(REQ_ADMIT_NORMAL, 3'd7);
    add_request(REQ_ADMIT_NORMAL, 3'd0);
    for (int s = 1; s <= MAX_SEVERITY; s++) begin
      add_request(REQ_ADMIT_URGENT, 3'(s));
    end
    add_request(REQ_ADMIT_URGENT, 3'd3);
    for (int i = 0; i < 8; i++) begin
      add_request(REQ_SERVE, 3'(i));
    end
    add_request(REQ_SERVE, 3'd5);

    add_random(240);
    wait_quiet();

    // empty every level with back-to-back serves and no output stalls
    steady = 1'b1;
    for (int i = 0; i < NUM_LEVELS * DEPTH_PER_LEVEL; i++) begin
      add_request(REQ_SERVE, 3'($urandom_range(0, 7)));
    end
    wait_quiet();
    steady = 1'b0;

    add_random(240);
    wait_quiet();
    repeat (20) @(posedge clk_i);

    $display("sent %0d requests, checked %0d responses", n_sent, n_checked);
    $display("level-full drops %0d, bad-severity drops %0d", n_full, n_bad_sev);
    if (mismatches == 0 && triage_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== two_class_severity_priority_queue.f =====
src/tcspq_pkg.sv
src/tcspq_ctrl.sv
src/tcspq_dp.sv
src/two_class_severity_priority_queue.sv
test/tb_two_class_severity_priority_queue.sv
